FILE: sv/tsta_pkg.sv
// shared types and constants for the traffic slot table with aging
package tsta_pkg;

  localparam int unsigned SlotCountDefault = 32;
  localparam logic [23:0] BackLongSeconds  = 24'd900;

  localparam logic [15:0] RealLimitReset   = 16'd3;
  localparam logic [15:0] GhostLimitReset  = 16'd60;
  localparam logic [15:0] ZombieLimitReset = 16'd600;

  typedef enum logic [1:0] {
    CFG_REAL_LIMIT   = 2'd0,
    CFG_GHOST_LIMIT  = 2'd1,
    CFG_ZOMBIE_LIMIT = 2'd2,
    CFG_UNUSED       = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_OBSERVE = 2'd0,
    OP_REFRESH = 2'd1,
    OP_LOCK    = 2'd2,
    OP_CLEAR   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_EMPTY  = 2'd0,
    ST_REAL   = 2'd1,
    ST_GHOST  = 2'd2,
    ST_ZOMBIE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    BACK_NONE  = 2'd0,
    BACK_SHORT = 2'd1,
    BACK_LONG  = 2'd2
  } back_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FETCH,
    S_APPLY,
    S_FIN
  } fsm_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [23:0] now;
    logic [23:0] target_id;
    logic [4:0]  slot_index;
    logic        lock_value;
  } in_item_t;

  typedef struct packed {
    logic [4:0] slot;
    logic       slot_ok;
    logic       was_new;
    logic       evicted;
    logic [1:0] back_visible;
    logic [5:0] removed_count;
    logic       lock_lost;
  } out_item_t;

  typedef struct packed {
    logic [23:0] ident;
    logic [23:0] fix;
    logic [1:0]  status;
    logic        lock;
  } entry_t;

endpackage

FILE: sv/tsta_mem.sv
// slot memory: one read and one write port, registered read, per-entry valid bits
module tsta_mem #(
  parameter int unsigned SlotCount = tsta_pkg::SlotCountDefault,
  parameter int unsigned Aw        = $clog2(SlotCount)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            rd_en_i,
  input  logic [Aw-1:0]   rd_addr_i,
  output tsta_pkg::entry_t rd_data_o,
  input  logic            wr_en_i,
  input  logic [Aw-1:0]   wr_addr_i,
  input  tsta_pkg::entry_t wr_data_i
);
  import tsta_pkg::*;

  entry_t               mem [SlotCount];
  logic [SlotCount-1:0] vld_q;
  entry_t               rd_q;
  logic                 rd_vld_q;

  // storage array
  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem[wr_addr_i] <= wr_data_i;
    if (rd_en_i) rd_q <= mem[rd_addr_i];
  end

  // valid bits: unwritten entries read as empty
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) vld_q[wr_addr_i] <= 1'b1;
      if (rd_en_i) rd_vld_q <= vld_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

FILE: sv/traffic_slot_table_aging.sv
// top level: sequencer walking the slot memory for observe, refresh, lock and clear
// observe scans all slots, then fetches and rewrites the pick (skipped if none or a zero id);
// refresh ages all slots; lock and clear update the indexed slot; a waiting result stalls finish
// throughput: one transaction at a time; the single memory read port walked per slot sets it
// reset: all slots read empty at once through per-entry valid bits, limits 3/60/600
module traffic_slot_table_aging #(
  parameter int unsigned SLOT_COUNT = tsta_pkg::SlotCountDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tsta_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tsta_pkg::out_item_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i
);
  import tsta_pkg::*;

  localparam int unsigned Aw = $clog2(SLOT_COUNT);
  localparam int unsigned Cw = $clog2(SLOT_COUNT + 1);

  fsm_e      state_q, state_d;
  in_item_t  item_q;
  out_item_t res_q, res_d, out_q;
  logic      out_vld_q;
  logic [15:0] real_lim_q, ghost_lim_q, zomb_lim_q;

  logic [Cw-1:0] cnt_q;
  logic          pv_q;
  logic [Aw-1:0] paddr_q;
  logic          issue;

  // scan results
  logic match_q, empty_q, zf_q, gf_q;
  logic [Aw-1:0] match_idx_q, empty_idx_q, z_idx_q, g_idx_q, pick_q;
  logic [23:0]   z_time_q, g_time_q;
  logic          evict_q, fresh_q;
  logic [Cw-1:0] removed_q;
  logic          lost_q;

  logic          rd_en, wr_en;
  logic [Aw-1:0] rd_addr, wr_addr;
  entry_t        rd_data, wr_data;

  logic          idx_ok;
  logic [Aw-1:0] idx_addr;
  logic          scan_done;

  assign idx_ok    = 32'(item_q.slot_index) < SLOT_COUNT;
  assign idx_addr  = Aw'(item_q.slot_index);
  assign issue     = (state_q == S_SCAN) && (32'(cnt_q) < SLOT_COUNT);
  assign scan_done = (state_q == S_SCAN) && !issue && !pv_q;

  tsta_mem #(.SlotCount(SLOT_COUNT), .Aw(Aw)) u_mem (
    .clk_i, .rst_ni,
    .rd_en_i(rd_en), .rd_addr_i(rd_addr), .rd_data_o(rd_data),
    .wr_en_i(wr_en), .wr_addr_i(wr_addr), .wr_data_i(wr_data)
  );

  // configuration registers
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      real_lim_q  <= RealLimitReset;
      ghost_lim_q <= GhostLimitReset;
      zomb_lim_q  <= ZombieLimitReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_REAL_LIMIT:   real_lim_q  <= cfg_data_i;
        CFG_GHOST_LIMIT:  ghost_lim_q <= cfg_data_i;
        CFG_ZOMBIE_LIMIT: zomb_lim_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_valid_i) begin
        unique case (op_e'(in_data_i.op))
          OP_OBSERVE: state_d = (in_data_i.target_id != '0) ? S_SCAN : S_FIN;
          OP_REFRESH: state_d = S_SCAN;
          OP_LOCK:    state_d = S_FETCH;
          OP_CLEAR:   state_d = S_FIN;
          default:    state_d = S_FIN;
        endcase
      end
      S_SCAN: if (scan_done) begin
        if (op_e'(item_q.op) == OP_OBSERVE && (match_q || empty_q || zf_q || gf_q))
          state_d = S_FETCH;
        else
          state_d = S_FIN;
      end
      S_FETCH: state_d = S_APPLY;
      S_APPLY: state_d = S_FIN;
      S_FIN:   if (!out_vld_q || out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // refresh aging of one returned entry
  logic [23:0] passed;
  entry_t      aged;
  logic        aged_rm, aged_lost;
  always_comb begin
    passed    = item_q.now - rd_data.fix;
    aged      = rd_data;
    aged_rm   = 1'b0;
    aged_lost = 1'b0;
    if (rd_data.ident != '0) begin
      if (item_q.now < rd_data.fix) begin
        aged      = '0;
        aged_rm   = 1'b1;
        aged_lost = rd_data.lock;
      end else if (passed > {8'd0, zomb_lim_q}) begin
        if (!rd_data.lock) begin
          aged    = '0;
          aged_rm = 1'b1;
        end
      end else if (passed > {8'd0, ghost_lim_q}) begin
        aged.status = ST_ZOMBIE;
      end else if (passed > {8'd0, real_lim_q}) begin
        aged.status = ST_GHOST;
      end else begin
        aged.status = ST_REAL;
      end
    end
  end

  // memory control and result
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cnt_q[Aw-1:0];
    wr_en   = 1'b0;
    wr_addr = paddr_q;
    wr_data = aged;
    res_d   = res_q;
    unique case (state_q)
      S_IDLE: res_d = '0;
      S_SCAN: begin
        rd_en = issue;
        wr_en = pv_q && (op_e'(item_q.op) == OP_REFRESH);
        if (scan_done) begin
          res_d.removed_count = 6'(removed_q);
          res_d.lock_lost     = lost_q;
        end
      end
      S_FETCH: begin
        rd_en   = 1'b1;
        rd_addr = (op_e'(item_q.op) == OP_LOCK) ? idx_addr : pick_q;
      end
      S_APPLY: begin
        wr_addr = (op_e'(item_q.op) == OP_LOCK) ? idx_addr : pick_q;
        wr_data = rd_data;
        if (op_e'(item_q.op) == OP_LOCK) begin
          wr_en        = idx_ok;
          wr_data.lock = item_q.lock_value;
        end else begin
          wr_en         = 1'b1;
          wr_data.ident = item_q.target_id;
          wr_data.fix   = item_q.now;
          if (evict_q) begin
            wr_data.status = ST_EMPTY;
            wr_data.lock   = 1'b0;
          end
          res_d.slot    = 5'(pick_q);
          res_d.slot_ok = 1'b1;
          res_d.was_new = fresh_q;
          res_d.evicted = evict_q;
          if (!fresh_q && !rd_data.lock && status_e'(rd_data.status) == ST_ZOMBIE) begin
            if (item_q.now >= rd_data.fix && (item_q.now - rd_data.fix) >= BackLongSeconds)
              res_d.back_visible = BACK_LONG;
            else
              res_d.back_visible = BACK_SHORT;
          end
        end
      end
      S_FIN: begin
        wr_en   = (op_e'(item_q.op) == OP_CLEAR) && idx_ok;
        wr_addr = idx_addr;
        wr_data = '0;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
      pv_q      <= 1'b0;
      cnt_q     <= '0;
    end else begin
      state_q <= state_d;
      pv_q    <= issue;
      if (state_q == S_IDLE) cnt_q <= '0;
      else if (issue)        cnt_q <= cnt_q + 1'b1;
      if (state_q == S_FIN && state_d == S_IDLE) out_vld_q <= 1'b1;
      else if (out_vld_q && out_ready_i)         out_vld_q <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    res_q   <= res_d;
    paddr_q <= cnt_q[Aw-1:0];
    if (state_q == S_FIN && state_d == S_IDLE) out_q <= res_q;
    if (state_q == S_IDLE) begin
      item_q    <= in_data_i;
      match_q   <= 1'b0;
      empty_q   <= 1'b0;
      zf_q      <= 1'b0;
      gf_q      <= 1'b0;
      removed_q <= '0;
      lost_q    <= 1'b0;
    end
    // one pass finds match, first empty and oldest unlocked zombie and ghost
    if (state_q == S_SCAN && pv_q) begin
      if (op_e'(item_q.op) == OP_REFRESH) begin
        if (aged_rm) removed_q <= removed_q + 1'b1;
        if (aged_lost) lost_q <= 1'b1;
      end else begin
        if (!match_q && rd_data.ident == item_q.target_id) begin
          match_q     <= 1'b1;
          match_idx_q <= paddr_q;
        end
        if (!empty_q && rd_data.ident == '0) begin
          empty_q     <= 1'b1;
          empty_idx_q <= paddr_q;
        end
        if (rd_data.ident != '0 && !rd_data.lock) begin
          if (status_e'(rd_data.status) == ST_ZOMBIE && (!zf_q || rd_data.fix < z_time_q)) begin
            zf_q     <= 1'b1;
            z_idx_q  <= paddr_q;
            z_time_q <= rd_data.fix;
          end
          if (status_e'(rd_data.status) == ST_GHOST && (!gf_q || rd_data.fix < g_time_q)) begin
            gf_q     <= 1'b1;
            g_idx_q  <= paddr_q;
            g_time_q <= rd_data.fix;
          end
        end
      end
    end
    if (scan_done) begin
      fresh_q <= !match_q;
      evict_q <= !match_q && !empty_q;
      if (match_q)      pick_q <= match_idx_q;
      else if (empty_q) pick_q <= empty_idx_q;
      else if (zf_q)    pick_q <= z_idx_q;
      else              pick_q <= g_idx_q;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // checks
  a_busy_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !in_ready_o) else $error("input taken while busy");
  a_evict_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.evicted) |-> (out_data_o.slot_ok && out_data_o.was_new))
    else $error("eviction without slot");
  a_back_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.back_visible != BACK_NONE) |-> !out_data_o.was_new)
    else $error("back report on new id");
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.removed_count != '0) |-> !out_data_o.slot_ok)
    else $error("refresh and observe fields mixed");

endmodule
